/* src/pgpsf_pkg.sv */
// Shared constants, payload types and helper functions of the pseudo-Gaussian PSF evaluator.
package pgpsf_pkg;

    localparam int COORD_BITS = 12;
    localparam int OFF_W      = 22;
    localparam int OFF_LIM    = 1048576;
    localparam int Z_W        = 27;
    localparam int Z_CAP      = 67108864;
    localparam int N_W        = 36;
    localparam int D_W        = 45;
    localparam int H_W        = 51;
    localparam int DIV3_STEPS = 6;
    localparam int DIV_STEPS  = 32;
    localparam int NUM_STAGES = 60;
    localparam int LAST       = NUM_STAGES - 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SKY_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_TERM = 3'd6;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } in_t;

    typedef struct packed {
        logic signed [31:0] model_value;
        logic [16:0]        deriv_peak;
        logic signed [39:0] deriv_center_x;
        logic signed [39:0] deriv_center_y;
        logic               clamped;
    } out_t;

    typedef struct packed {
        logic signed [H_W-1:0] hx;
        logic signed [H_W-1:0] hy;
        logic                  clamped;
    } side_t;

    function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [31:0] v);
        logic signed [OFF_W-1:0] r;
        if (v > OFF_LIM) begin
            r = OFF_W'(OFF_LIM);
        end else if (v < -OFF_LIM) begin
            r = OFF_W'(-OFF_LIM);
        end else begin
            r = OFF_W'(v);
        end
        return r;
    endfunction

    // Eight bits of a long division by three; returns the remainder above the quotient bits.
    function automatic logic [9:0] div3_step8(input logic [1:0] rem, input logic [7:0] bits);
        logic [2:0] t;
        logic [1:0] r;
        logic [7:0] q;
        r = rem;
        for (int i = 7; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= 3'd3) begin
                q[i] = 1'b1;
                r = 2'(t - 3'd3);
            end else begin
                q[i] = 1'b0;
                r = t[1:0];
            end
        end
        return {r, q};
    endfunction

endpackage

/* src/pseudo_gaussian_psf_eval.sv */
// Top level of the pseudo-Gaussian PSF evaluator: a 60-stage pipeline with a restoring divider.
//
//  Channel  Ports                        Direction  Content
//  s_       s_valid s_ready s_data       in         one pixel coordinate per request
//  m_       m_valid m_ready m_data       out        model, gradient and clamp flag
//  cfg_     cfg_we cfg_index cfg_data    in         register writes, taken at once
//
// One request enters per cycle while the output is not stalled, and the depth of the pipeline
// is set mostly by the 32-stage division that forms the shape value.
// Reset is synchronous and active low; it empties the pipeline and loads register defaults.
// Every stage holds its request until the next stage has room, so a stalled output
// keeps accepting requests until the bubbles ahead of it are filled.
module pseudo_gaussian_psf_eval (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  pgpsf_pkg::in_t                       s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output pgpsf_pkg::out_t                      m_data,
    input  logic                                 cfg_we,
    input  logic [pgpsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pgpsf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pgpsf_pkg::*;

    logic [19:0]        center_x_reg, center_y_reg;
    logic [23:0]        peak_level_reg;
    logic signed [23:0] sky_level_reg;
    logic [15:0]        scale_x_reg, scale_y_reg;
    logic signed [15:0] cross_term_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            peak_level_reg <= 24'd10000;
            sky_level_reg  <= '0;
            scale_x_reg    <= 16'd19251;
            scale_y_reg    <= 16'd19251;
            cross_term_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CENTER_X:   center_x_reg   <= cfg_data[19:0];
                REG_CENTER_Y:   center_y_reg   <= cfg_data[19:0];
                REG_PEAK_LEVEL: peak_level_reg <= cfg_data;
                REG_SKY_LEVEL:  sky_level_reg  <= $signed(cfg_data);
                REG_SCALE_X:    scale_x_reg    <= cfg_data[15:0];
                REG_SCALE_Y:    scale_y_reg    <= cfg_data[15:0];
                REG_CROSS_TERM: cross_term_reg <= $signed(cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[LAST] = !v_reg[LAST] || m_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[LAST];

    // Stage 0: offsets from the center.
    logic signed [OFF_W-1:0] x0_reg, y0_reg;
    logic signed [31:0]      dx0, dy0;
    assign dx0 = $signed(32'({s_data.pixel_x, 8'd0})) - $signed(32'(center_x_reg));
    assign dy0 = $signed(32'({s_data.pixel_y, 8'd0})) - $signed(32'(center_y_reg));
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x0_reg <= sat_off(dx0);
            y0_reg <= sat_off(dy0);
        end
    end

    // Stage 1: scaled offsets and cross products.
    logic signed [38:0] mx1_reg, my1_reg;
    logic signed [43:0] xy1_reg;
    logic signed [37:0] cyh1_reg, cxh1_reg;
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            mx1_reg  <= $signed({1'b0, scale_x_reg}) * x0_reg;
            my1_reg  <= $signed({1'b0, scale_y_reg}) * y0_reg;
            xy1_reg  <= x0_reg * y0_reg;
            cyh1_reg <= cross_term_reg * y0_reg;
            cxh1_reg <= cross_term_reg * x0_reg;
        end
    end

    // Stage 2: px and py rounded to Q.16, cross term of z.
    logic signed [31:0] px2_reg, py2_reg;
    logic signed [59:0] cxy2_reg;
    logic signed [37:0] cyh2_reg, cxh2_reg;
    logic signed [39:0] tx2, ty2;
    assign tx2 = 40'(mx1_reg) + 40'sd32;
    assign ty2 = 40'(my1_reg) + 40'sd32;
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            px2_reg  <= 32'(tx2 >>> 6);
            py2_reg  <= 32'(ty2 >>> 6);
            cxy2_reg <= cross_term_reg * xy1_reg;
            cyh2_reg <= cyh1_reg;
            cxh2_reg <= cxh1_reg;
        end
    end

    // Stage 3: squares and gradient products.
    logic signed [63:0] pp3_reg, qq3_reg;
    logic signed [48:0] pxs3_reg, pys3_reg;
    logic signed [59:0] cxy3_reg;
    logic signed [37:0] cyh3_reg, cxh3_reg;
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            pp3_reg  <= px2_reg * px2_reg;
            qq3_reg  <= py2_reg * py2_reg;
            pxs3_reg <= px2_reg * $signed({1'b0, scale_x_reg});
            pys3_reg <= py2_reg * $signed({1'b0, scale_y_reg});
            cxy3_reg <= cxy2_reg;
            cyh3_reg <= cyh2_reg;
            cxh3_reg <= cxh2_reg;
        end
    end

    // Stage 4: z in Q.33 and the center gradient factors.
    logic signed [63:0]    z33_4_reg;
    logic signed [H_W-1:0] hx4_reg, hy4_reg;
    always_ff @(posedge aclk) begin
        if (en[4]) begin
            z33_4_reg <= pp3_reg + qq3_reg + (64'(cxy3_reg) <<< 3);
            hx4_reg   <= (H_W'(pxs3_reg) <<< 1) + (H_W'(cyh3_reg) <<< 8);
            hy4_reg   <= (H_W'(pys3_reg) <<< 1) + (H_W'(cxh3_reg) <<< 8);
        end
    end

    // Stage 5: clamp, round and cap z.
    side_t          sd_reg [5:LAST];
    logic [Z_W-1:0] z_reg  [5:8];
    logic [63:0]    zt5;
    logic [46:0]    zs5;
    logic           neg5;
    logic [Z_W-1:0] z5;
    assign zt5  = $unsigned(z33_4_reg) + 64'd65536;
    assign zs5  = zt5[63:17];
    assign neg5 = z33_4_reg[63];
    always_comb begin
        if (neg5) begin
            z5 = '0;
        end else if (zs5 > 47'(Z_CAP)) begin
            z5 = Z_W'(Z_CAP);
        end else begin
            z5 = zs5[Z_W-1:0];
        end
    end
    always_ff @(posedge aclk) begin
        if (en[5]) begin
            z_reg[5]          <= z5;
            sd_reg[5].hx      <= hx4_reg;
            sd_reg[5].hy      <= hy4_reg;
            sd_reg[5].clamped <= neg5;
        end
    end

    for (genvar k = 6; k <= LAST; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    for (genvar k = 6; k <= 8; k++) begin : g_z
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                z_reg[k] <= z_reg[k-1];
            end
        end
    end

    // Stages 6 to 10: powers of z, numerator and the term to be divided by six.
    logic [52:0]    zz6_reg;
    logic [36:0]    z2_reg [7:8];
    logic [63:0]    z2z8_reg;
    logic [46:0]    z3_9_reg;
    logic [N_W-1:0] n_reg [9:52];
    logic [47:0]    v10_reg;
    logic [53:0]    zzr7;
    logic [63:0]    z3r9;
    logic [37:0]    hz9;
    logic [47:0]    vr10;
    assign zzr7 = (54'(zz6_reg) + 54'd32768) >> 16;
    assign z3r9 = (z2z8_reg + 64'd32768) >> 16;
    assign hz9  = (38'(z2_reg[8]) + 38'd1) >> 1;
    assign vr10 = (48'(z3_9_reg) + 48'd3) >> 1;
    always_ff @(posedge aclk) begin
        if (en[6]) begin
            zz6_reg <= z_reg[5] * z_reg[5];
        end
        if (en[7]) begin
            z2_reg[7] <= zzr7[36:0];
        end
        if (en[8]) begin
            z2z8_reg  <= z2_reg[7] * z_reg[7];
            z2_reg[8] <= z2_reg[7];
        end
        if (en[9]) begin
            z3_9_reg <= z3r9[46:0];
            n_reg[9] <= N_W'(38'd65536 + 38'(z_reg[8]) + hz9);
        end
        if (en[10]) begin
            v10_reg <= vr10;
        end
    end

    for (genvar k = 10; k <= 52; k++) begin : g_n
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                n_reg[k] <= n_reg[k-1];
            end
        end
    end

    // Stages 11 to 16: division by three, eight quotient bits per stage.
    logic [47:0] d3w_reg [DIV3_STEPS];
    logic [1:0]  d3r_reg [DIV3_STEPS];
    for (genvar j = 0; j < DIV3_STEPS; j++) begin : g_div3
        logic [47:0] w_in;
        logic [1:0]  r_in;
        logic [9:0]  st;
        if (j == 0) begin : g_first
            assign w_in = v10_reg;
            assign r_in = 2'd0;
        end else begin : g_rest
            assign w_in = d3w_reg[j-1];
            assign r_in = d3r_reg[j-1];
        end
        assign st = div3_step8(r_in, w_in[47:40]);
        always_ff @(posedge aclk) begin
            if (en[11+j]) begin
                d3w_reg[j] <= {w_in[39:0], st[7:0]};
                d3r_reg[j] <= st[9:8];
            end
        end
    end

    // Stages 17 and 18: denominator and rounded dividend.
    logic [D_W-1:0] d_reg [17:49];
    logic [47:0]    num18_reg;
    always_ff @(posedge aclk) begin
        if (en[17]) begin
            d_reg[17] <= D_W'(n_reg[16]) + D_W'(d3w_reg[DIV3_STEPS-1]);
        end
        if (en[18]) begin
            num18_reg <= 48'h8000_0000_0000 + 48'(d_reg[17] >> 1);
        end
    end

    for (genvar k = 18; k <= 49; k++) begin : g_d
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                d_reg[k] <= d_reg[k-1];
            end
        end
    end

    // Stages 19 to 50: restoring division, one quotient bit per stage.
    logic [D_W-1:0] dvr_reg [DIV_STEPS];
    logic [31:0]    dvw_reg [DIV_STEPS];
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [D_W-1:0] r_in;
        logic [31:0]    w_in;
        logic [D_W:0]   t;
        logic           ge;
        logic [D_W:0]   diff;
        if (j == 0) begin : g_first
            assign r_in = D_W'(num18_reg[47:32]);
            assign w_in = num18_reg[31:0];
        end else begin : g_rest
            assign r_in = dvr_reg[j-1];
            assign w_in = dvw_reg[j-1];
        end
        assign t    = {r_in, w_in[31]};
        assign ge   = t >= (D_W+1)'(d_reg[18+j]);
        assign diff = t - (D_W+1)'(d_reg[18+j]);
        always_ff @(posedge aclk) begin
            if (en[19+j]) begin
                dvr_reg[j] <= ge ? diff[D_W-1:0] : t[D_W-1:0];
                dvw_reg[j] <= {w_in[30:0], ge};
            end
        end
    end

    // Stages 51 to 55: model value, peak derivative and the gradient scale q.
    logic [31:0]        r31;
    logic [55:0]        mpr51_reg;
    logic [63:0]        rr51_reg;
    logic [16:0]        dpk_reg [51:LAST];
    logic signed [31:0] model_reg [52:LAST];
    logic [31:0]        r2_52_reg;
    logic [67:0]        rn53_reg;
    logic [32:0]        g54_reg;
    logic [56:0]        q55_reg;
    logic [32:0]        dpr51;
    logic [56:0]        mt52;
    logic signed [35:0] ms52;
    logic signed [31:0] model52;
    logic [63:0]        r2t52;
    logic [67:0]        gt54;

    assign r31   = dvw_reg[DIV_STEPS-1];
    assign dpr51 = (33'(r31) + 33'd16384) >> 15;
    assign mt52  = (57'(mpr51_reg) + 57'd4194304) >> 23;
    assign ms52  = $signed({2'b00, mt52[33:0]}) + (36'(sky_level_reg) <<< 8);
    assign r2t52 = (rr51_reg + 64'h4000_0000) >> 31;
    assign gt54  = (rn53_reg + 68'd32768) >> 16;
    always_comb begin
        if (ms52 > 36'sd2147483647) begin
            model52 = 32'sh7FFF_FFFF;
        end else if (ms52 < -36'sd2147483648) begin
            model52 = 32'sh8000_0000;
        end else begin
            model52 = ms52[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[51]) begin
            mpr51_reg   <= peak_level_reg * r31;
            rr51_reg    <= r31 * r31;
            dpk_reg[51] <= dpr51[16:0];
        end
        if (en[52]) begin
            model_reg[52] <= model52;
            r2_52_reg     <= r2t52[31:0];
        end
        if (en[53]) begin
            rn53_reg <= r2_52_reg * n_reg[52];
        end
        if (en[54]) begin
            g54_reg <= gt54[32:0];
        end
        if (en[55]) begin
            q55_reg <= peak_level_reg * g54_reg;
        end
    end

    for (genvar k = 52; k <= LAST; k++) begin : g_dpk
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                dpk_reg[k] <= dpk_reg[k-1];
            end
        end
    end

    for (genvar k = 53; k <= LAST; k++) begin : g_model
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                model_reg[k] <= model_reg[k-1];
            end
        end
    end

    // Stages 55 to 59: center derivatives as q times |h| from partial products.
    logic signed [39:0] dv_reg [2];
    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic signed [H_W-1:0] h54;
        logic [H_W-1:0]        mg55_reg;
        logic [54:0]           ll56_reg;
        logic [53:0]           lh56_reg;
        logic [53:0]           hl56_reg;
        logic [52:0]           hh56_reg;
        logic [80:0]           s1_57_reg;
        logic [80:0]           s2_57_reg;
        logic [55:0]           mag58_reg;
        logic [109:0]          pt58;
        logic                  neg59;
        logic [55:0]           lim59;
        logic [55:0]           mc59;
        logic [55:0]           sg59;

        assign h54   = (a == 0) ? sd_reg[54].hx : sd_reg[54].hy;
        assign pt58  = 110'(s1_57_reg) + (110'(s2_57_reg) << 29) + (110'(1) << 52);
        assign neg59 = (a == 0) ? sd_reg[58].hx[H_W-1] : sd_reg[58].hy[H_W-1];
        assign lim59 = neg59 ? (56'(1) << 39) : ((56'(1) << 39) - 56'd1);
        assign mc59  = (mag58_reg > lim59) ? lim59 : mag58_reg;
        assign sg59  = neg59 ? (56'd0 - mc59) : mc59;

        always_ff @(posedge aclk) begin
            if (en[55]) begin
                mg55_reg <= h54[H_W-1] ? H_W'(-h54) : H_W'(h54);
            end
            if (en[56]) begin
                ll56_reg <= q55_reg[28:0] * mg55_reg[25:0];
                lh56_reg <= q55_reg[28:0] * mg55_reg[50:26];
                hl56_reg <= q55_reg[56:29] * mg55_reg[25:0];
                hh56_reg <= q55_reg[56:29] * mg55_reg[50:26];
            end
            if (en[57]) begin
                s1_57_reg <= 81'(ll56_reg) + (81'(lh56_reg) << 26);
                s2_57_reg <= (81'(hh56_reg) << 26) + 81'(hl56_reg);
            end
            if (en[58]) begin
                mag58_reg <= pt58[108:53];
            end
            if (en[59]) begin
                dv_reg[a] <= $signed(sg59[39:0]);
            end
        end
    end

    assign m_data.model_value    = model_reg[LAST];
    assign m_data.deriv_peak     = dpk_reg[LAST];
    assign m_data.deriv_center_x = dv_reg[0];
    assign m_data.deriv_center_y = dv_reg[1];
    assign m_data.clamped        = sd_reg[LAST].clamped;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the pseudo-Gaussian PSF evaluator with its own predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pgpsf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = NUM_STAGES + 20;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pseudo_gaussian_psf_eval i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [19:0] cfg_cx = 20'd0;
    logic [19:0] cfg_cy = 20'd0;
    logic [23:0] cfg_pk = 24'd10000;
    logic signed [23:0] cfg_sky = 24'sd0;
    logic [15:0] cfg_sx = 16'd19251;
    logic [15:0] cfg_sy = 16'd19251;
    logic signed [15:0] cfg_ct = 16'sd0;

    in_t pixel_queue[$];
    out_t profile_queue[$];
    int errors = 0;
    int cycles = 0;
    int pixels_sent = 0;
    int profiles_seen = 0;
    int clamp_seen = 0;
    int phases_run = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    bit req_taken = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [39:0] center_grad(longint unsigned q, longint h);
        logic [127:0] prod;
        logic [127:0] lim;
        logic [127:0] res;
        longint unsigned m;
        m = (h < 0) ? longint'(-h) : longint'(h);
        lim = (h < 0) ? 128'd549755813888 : 128'd549755813887;
        prod = {64'd0, q} * {64'd0, m};
        prod = (prod + (128'd1 << 52)) >> 53;
        if (prod > lim) prod = lim;
        res = (h < 0) ? -prod : prod;
        return res[39:0];
    endfunction

    function automatic out_t psf_predict(in_t pix);
        longint xo, yo, pxs, pys, z33, model, hx, hy;
        longint unsigned z, z2, z3, nn, dd, r31, r2, g, q, rp;
        logic clamp;
        out_t o;
        xo = longint'(pix.pixel_x) * 256 - longint'(cfg_cx);
        yo = longint'(pix.pixel_y) * 256 - longint'(cfg_cy);
        pxs = (longint'(cfg_sx) * xo + 32) >>> 6;
        pys = (longint'(cfg_sy) * yo + 32) >>> 6;
        z33 = pxs * pxs + pys * pys + longint'(cfg_ct) * (xo * yo) * 8;
        clamp = (z33 < 0);
        z = clamp ? 64'd0 : longint'((z33 + 65536) >>> 17);
        if (z > Z_CAP) z = Z_CAP;
        z2 = (z * z + 32768) >> 16;
        z3 = (z2 * z + 32768) >> 16;
        nn = 65536 + z + ((z2 + 1) >> 1);
        dd = nn + (z3 + 3) / 6;
        r31 = ((64'd1 << 47) + (dd >> 1)) / dd;
        model = ((longint'(cfg_pk * r31) + 4194304) >>> 23) + longint'(cfg_sky) * 256;
        if (model > 64'sd2147483647) model = 64'sd2147483647;
        if (model < -64'sd2147483648) model = -64'sd2147483648;
        r2 = (r31 * r31 + (64'd1 << 30)) >> 31;
        g = (r2 * nn + 32768) >> 16;
        q = cfg_pk * g;
        hx = 2 * pxs * longint'(cfg_sx) + longint'(cfg_ct) * yo * 256;
        hy = 2 * pys * longint'(cfg_sy) + longint'(cfg_ct) * xo * 256;
        rp = (r31 + 16384) >> 15;
        o.model_value = model[31:0];
        o.deriv_peak = rp[16:0];
        o.deriv_center_x = center_grad(q, hx);
        o.deriv_center_y = center_grad(q, hy);
        o.clamped = clamp;
        return o;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("mismatch on profile %0d, %s: got %0h, expected %0h",
                 profiles_seen, field, got, want);
    endtask

    always @(posedge aclk) begin
        out_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top NOT OK");
            $finish;
        end
        req_taken = aresetn && s_valid && s_ready;
        if (req_taken) begin
            profile_queue.push_back(psf_predict(s_data));
            pixels_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (profile_queue.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = profile_queue.pop_front();
                if (m_data.model_value !== want.model_value)
                    report_mismatch("model_value", m_data.model_value, want.model_value);
                if (m_data.deriv_peak !== want.deriv_peak)
                    report_mismatch("deriv_peak", m_data.deriv_peak, want.deriv_peak);
                if (m_data.deriv_center_x !== want.deriv_center_x)
                    report_mismatch("deriv_center_x", m_data.deriv_center_x,
                                    want.deriv_center_x);
                if (m_data.deriv_center_y !== want.deriv_center_y)
                    report_mismatch("deriv_center_y", m_data.deriv_center_y,
                                    want.deriv_center_y);
                if (m_data.clamped !== want.clamped)
                    report_mismatch("clamped", m_data.clamped, want.clamped);
                if (want.clamped) clamp_seen++;
            end
            profiles_seen++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                s_data <= pixel_queue.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_CENTER_X:   cfg_cx = val[19:0];
            REG_CENTER_Y:   cfg_cy = val[19:0];
            REG_PEAK_LEVEL: cfg_pk = val;
            REG_SKY_LEVEL:  cfg_sky = val;
            REG_SCALE_X:    cfg_sx = val[15:0];
            REG_SCALE_Y:    cfg_sy = val[15:0];
            REG_CROSS_TERM: cfg_ct = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_profile(logic [23:0] cx, logic [23:0] cy, logic [23:0] pk,
                               logic [23:0] sky, logic [23:0] sx, logic [23:0] sy,
                               logic [23:0] ct);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_PEAK_LEVEL, pk);
        write_reg(REG_SKY_LEVEL, sky);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_CROSS_TERM, ct);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(int x, int y);
        in_t p;
        p.pixel_x = x[COORD_BITS-1:0];
        p.pixel_y = y[COORD_BITS-1:0];
        pixel_queue.push_back(p);
    endtask

    task automatic load_random(int count);
        int cx, cy;
        cx = cfg_cx >> 8;
        cy = cfg_cy >> 8;
        repeat (count) begin
            if ($urandom_range(99) < 70)
                push_pixel(cx + $urandom_range(0, 24) - 12, cy + $urandom_range(0, 24) - 12);
            else
                push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
    endtask

    task automatic wait_idle();
        wait (pixel_queue.size() == 0 && !s_valid && profile_queue.size() == 0);
        @(posedge aclk);
        phases_run++;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: corners, center and far pixels that saturate z.
        stall_pct = 0;
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(0, 4095);
        push_pixel(4095, 0);
        push_pixel(1, 0);
        push_pixel(0, 1);
        push_pixel(2048, 2048);
        wait_idle();

        // Near-center pixels and a strong negative cross term that drives z below zero.
        set_profile(24'h006480, 24'h00C840, 24'd50000, 24'hFFFC18, 24'd19251, 24'd19251,
                    24'h008000);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        @(negedge aclk);
        cfg_we <= 1'b0;
        push_pixel(100, 200);
        push_pixel(101, 201);
        push_pixel(102, 202);
        push_pixel(98, 198);
        push_pixel(103, 197);
        push_pixel(100, 210);
        push_pixel(4095, 4095);
        wait_idle();

        // All registers at their maximum.
        set_profile(24'h0FFFFF, 24'h0FFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h00FFFF, 24'h00FFFF,
                    24'h007FFF);
        push_pixel(4095, 4095);
        push_pixel(4094, 4095);
        push_pixel(0, 0);
        push_pixel(4095, 0);
        wait_idle();

        // All registers at their minimum.
        set_profile(24'h000000, 24'h000000, 24'h000000, 24'h800000, 24'h000000, 24'h000000,
                    24'h008000);
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(4095, 1);
        wait_idle();

        // Random profiles; the first one holds the output back so the pipeline backs up.
        for (int ph = 0; ph < 7; ph++) begin
            set_profile(24'($urandom_range(0, 20'hFFFFF)), 24'($urandom_range(0, 20'hFFFFF)),
                        24'($urandom), 24'($urandom),
                        24'(($urandom_range(99) < 50) ? $urandom_range(0, 3000) : $urandom),
                        24'(($urandom_range(99) < 50) ? $urandom_range(0, 3000) : $urandom),
                        24'(($urandom_range(99) < 50) ? $urandom_range(0, 600) - 300
                                                      : $urandom));
            stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 70);
            @(posedge aclk);
            if (ph == 0) hold_cycles = 400;
            load_random(120);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (profile_queue.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", profile_queue.size());
        end
        $display("Covered %0d pixels over %0d register settings, %0d results, %0d clamped.",
                 pixels_sent, phases_run, profiles_seen, clamp_seen);
        $display("Failures counted: %0d.", errors);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
